// File: rtl/core/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
// Depends on nothing; every module of the core imports it.
`default_nettype none

package tcw_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CIDX_W   = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 8;
    // Full linear index over the largest grid a 7-bit column and 5-bit row can name
    localparam int IDX_W    = COL_W + ROW_W;
    localparam int TAB_SPAN = 1 << COL_W;

    // Default geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd15;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_PUT_CHAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_CURSOR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_CELL  = 2'd3;

    // Control bytes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } in_item_t;

    typedef struct packed {
        logic [CIDX_W-1:0] cursor_index;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_data;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_GLYPH,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_SET_CURSOR,
        OP_READ
    } op_t;

    // Classified request; column and row already saturated to the grid
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } cmd_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_FILL,
        BS_SCROLL_COPY,
        BS_SCROLL_DRAIN,
        BS_SCROLL_BLANK,
        BS_CLEAR,
        BS_REPORT
    } bstate_t;

    // One bit per column value: set where the column is a tab stop
    function automatic logic [TAB_SPAN-1:0] tab_stop_mask(input int tw);
        logic [TAB_SPAN-1:0] mask;
        int                  phase;
        mask  = '0;
        phase = 0;
        for (int i = 0; i < TAB_SPAN; i++) begin
            mask[i] = (phase == 0);
            phase   = (phase == tw - 1) ? 0 : phase + 1;
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tcw_front.sv
// Front end: takes requests, decodes control bytes and saturates coordinates.
// Depends on tcw_pkg; feeds tcw_queue.
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire              s_valid,
    output logic             s_ready,
    input  tcw_pkg::in_item_t s_data,
    input  wire              q_ready,
    output logic             q_push,
    output tcw_pkg::cmd_t    q_cmd
);
    import tcw_pkg::*;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    always_comb begin
        q_cmd.char_code = s_data.char_code;
        q_cmd.column    = (s_data.column > COL_MAX) ? COL_MAX : s_data.column;
        q_cmd.row       = (s_data.row > ROW_MAX) ? ROW_MAX : s_data.row;
        case (s_data.func)
            FUNC_PUT_CHAR: begin
                case (s_data.char_code)
                    CH_NEWLINE:   q_cmd.op = OP_NEWLINE;
                    CH_RETURN:    q_cmd.op = OP_RETURN;
                    CH_TAB:       q_cmd.op = OP_TAB;
                    CH_BACKSPACE: q_cmd.op = OP_BACKSPACE;
                    default:      q_cmd.op = OP_GLYPH;
                endcase
            end
            FUNC_CLEAR:      q_cmd.op = OP_CLEAR;
            FUNC_SET_CURSOR: q_cmd.op = OP_SET_CURSOR;
            FUNC_READ_CELL:  q_cmd.op = OP_READ;
            default:         q_cmd.op = OP_READ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_queue.sv
// Short request queue between the front end and the executor.
// Depends on tcw_pkg for the request type and depth.
`default_nettype none

module tcw_queue (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            push,
    input  tcw_pkg::cmd_t  push_cmd,
    output logic           push_ready,
    input  wire            pop,
    output logic           head_valid,
    output tcw_pkg::cmd_t  head_cmd
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_back.sv
// Executor: owns the cursor and the cell memory, runs one request at a time
// and holds the result register. Depends on tcw_pkg; fed by tcw_queue.
`default_nettype none

module tcw_back #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire [tcw_pkg::COLOR_W-1:0]   text_color,
    input  wire                          head_valid,
    input  tcw_pkg::cmd_t                head_cmd,
    output logic                         pop,
    output logic                         m_valid,
    input  wire                          m_ready,
    output tcw_pkg::out_item_t           m_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [COL_W-1:0]    COL_MAX   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]    ROW_MAX   = ROW_W'(ROWS - 1);
    localparam logic [AW-1:0]       ROW_STEP  = AW'(COLUMNS);
    localparam logic [AW-1:0]       COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [AW-1:0]       CELL_LAST = AW'(CELLS - 1);
    localparam logic [TAB_SPAN-1:0] TAB_STOPS = tab_stop_mask(TAB_WIDTH);

    // Cell memory: one write and one registered read per cycle
    logic [CELL_W-1:0] mem [CELLS];
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, rdata_reg;

    bstate_t           state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              fill_tab_reg, fill_tab_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [IDX_W-1:0]  cur_lin, head_lin;
    logic [AW-1:0]     cur_addr, head_addr;
    logic              wrap, scroll, at_stop, fill_done, slot_free;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W-1:0]  adv_row;
    logic [CELL_W-1:0] blank_cell;

    assign cur_lin    = IDX_W'(int'(row_reg) * COLUMNS) + IDX_W'(col_reg);
    assign head_lin   = IDX_W'(int'(head_cmd.row) * COLUMNS) + IDX_W'(head_cmd.column);
    assign cur_addr   = cur_lin[AW-1:0];
    assign head_addr  = head_lin[AW-1:0];
    assign blank_cell = {text_color, CH_BLANK};

    // Cursor step after one cell write
    assign wrap      = (col_reg == COL_MAX);
    assign scroll    = wrap && (row_reg == ROW_MAX);
    assign adv_col   = wrap ? '0 : col_reg + COL_W'(1);
    assign adv_row   = (wrap && !scroll) ? row_reg + ROW_W'(1) : row_reg;
    assign at_stop   = TAB_STOPS[col_reg];
    assign fill_done = fill_tab_reg ? TAB_STOPS[adv_col] : (adv_col == '0);
    assign slot_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE: begin
                if (head_valid) begin
                    case (head_cmd.op)
                        OP_GLYPH:   state_next = scroll ? BS_SCROLL_COPY : BS_REPORT;
                        OP_NEWLINE: state_next = BS_FILL;
                        OP_TAB:     state_next = at_stop ? BS_REPORT : BS_FILL;
                        OP_READ:    state_next = BS_READ;
                        OP_CLEAR:   state_next = BS_CLEAR;
                        default:    state_next = BS_REPORT;
                    endcase
                end
            end
            BS_FILL: begin
                if (scroll) begin
                    state_next = BS_SCROLL_COPY;
                end else if (fill_done) begin
                    state_next = BS_REPORT;
                end
            end
            BS_SCROLL_COPY:  if (ptr_reg == COPY_LAST) state_next = BS_SCROLL_DRAIN;
            BS_SCROLL_DRAIN: state_next = BS_SCROLL_BLANK;
            BS_SCROLL_BLANK: if (ptr_reg == CELL_LAST) state_next = BS_REPORT;
            BS_CLEAR:        if (ptr_reg == CELL_LAST) state_next = BS_REPORT;
            BS_READ:         state_next = BS_REPORT;
            BS_REPORT:       if (slot_free) state_next = BS_IDLE;
            default:         state_next = BS_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = blank_cell;
        mem_re         = 1'b0;
        mem_raddr      = head_addr;
        col_next       = col_reg;
        row_next       = row_reg;
        ptr_next       = ptr_reg;
        fill_tab_next  = fill_tab_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            BS_IDLE: begin
                if (head_valid) begin
                    pop       = 1'b1;
                    data_next = '0;
                    case (head_cmd.op)
                        OP_GLYPH: begin
                            mem_we    = 1'b1;
                            mem_wdata = {text_color, head_cmd.char_code};
                            col_next  = adv_col;
                            row_next  = adv_row;
                            ptr_next  = '0;
                        end
                        OP_NEWLINE:   fill_tab_next = 1'b0;
                        OP_TAB:       fill_tab_next = 1'b1;
                        OP_RETURN:    col_next = '0;
                        OP_BACKSPACE: begin
                            if (col_reg != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr - AW'(1);
                                col_next  = col_reg - COL_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            ptr_next = '0;
                            col_next = '0;
                            row_next = '0;
                        end
                        OP_SET_CURSOR: begin
                            col_next = head_cmd.column;
                            row_next = head_cmd.row;
                        end
                        OP_READ:  mem_re = 1'b1;
                        default:  mem_re = 1'b0;
                    endcase
                end
            end
            BS_FILL: begin
                mem_we   = 1'b1;
                col_next = adv_col;
                row_next = adv_row;
                ptr_next = '0;
            end
            BS_SCROLL_COPY: begin
                // read one row down, write it back in the next cycle
                mem_re         = 1'b1;
                mem_raddr      = ptr_reg + ROW_STEP;
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg;
                mem_we         = pend_reg;
                mem_waddr      = pend_addr_reg;
                mem_wdata      = rdata_reg;
                ptr_next       = ptr_reg + AW'(1);
            end
            BS_SCROLL_DRAIN: begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_reg;
                mem_wdata = rdata_reg;
            end
            BS_SCROLL_BLANK, BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                ptr_next  = ptr_reg + AW'(1);
            end
            BS_READ: data_next = rdata_reg;
            BS_REPORT: begin
                if (slot_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.cursor_index  = cur_lin[CIDX_W-1:0];
                    out_data_next.cursor_column = col_reg;
                    out_data_next.cursor_row    = row_reg;
                    out_data_next.cell_data     = data_reg;
                end
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        fill_tab_reg  <= fill_tab_next;
        pend_addr_reg <= pend_addr_next;
        data_reg      <= data_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_MAX)
        else $error("cursor column beyond last column");

    a_row_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_MAX)
        else $error("cursor row beyond last row");

    a_result_from_report: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == BS_REPORT)
        else $error("result loaded outside report step");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == BS_IDLE) && head_valid)
        else $error("request taken while busy");

    a_copy_then_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BS_SCROLL_DRAIN) |-> pend_reg && $past(state_reg) == BS_SCROLL_COPY)
        else $error("scroll drain without pending copy");
`endif

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer_core.sv
// Text console writer, top level: configuration register, front end,
// request queue and executor. Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
`default_nettype none

// Text-mode console engine over a COLUMNS x ROWS grid of 16-bit cells
// (attribute byte above character byte), held in a single-port-write,
// registered-read memory inside the executor. Each request on the s_ channel
// yields exactly one result on the m_ channel carrying the cursor position
// after the request and, for a cell read, the cell contents (zero otherwise).
// The attribute for every write is the value last written through cfg_wr_en /
// cfg_wr_data (15 after reset); change it only while no request is in flight.
// Every request ends in the report step, which loads its result once the
// result register is free. A cell read first waits on the registered memory
// read. Newline writes blanks to the end of the row, tab up to the next tab
// stop, and clear screen writes every cell. Any write that runs off the last
// row adds a scroll: the lower ROWS-1 rows are copied up by one row and the
// last row is blanked. The memory has one write port, so every written cell,
// blank or copied, is written on its own. The two-entry queue takes up to two
// requests while the executor works or a result waits for m_ready; s_ready
// drops once both entries are held.
// Reading a cell that was never written since reset returns undefined data.
module text_console_writer_core #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [tcw_pkg::COLOR_W-1:0]  cfg_wr_data,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  tcw_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  wire                         m_ready,
    output tcw_pkg::out_item_t          m_data
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] text_color_reg, text_color_next;

    // Front end to queue
    logic q_ready;
    logic q_push;
    cmd_t q_cmd;

    // Queue to executor
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // Hold the attribute until software writes a new one
    assign text_color_next = cfg_wr_en ? cfg_wr_data : text_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= TEXT_COLOR_RESET;
        end else begin
            text_color_reg <= text_color_next;
        end
    end

    // Decode control bytes and clamp coordinates on the way in
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // Decouple intake from execution
    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Advance the cursor, walk the cell memory and drive the result
    tcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .text_color (text_color_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
